// ----- hw/rtl/bbo_pkg.sv -----
// Shared types and constants for the box/ball overlap test block.
// Used by bbo_sqrt, bbo_ctrl, bbo_datapath and box_ball_overlap_test_core.
package bbo_pkg;

    localparam int COORD_W = 16;
    localparam int MAG_W   = 16;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = 38;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int DIST_W  = 18;
    localparam int REM_W   = ROOT_W + 1;
    localparam int CNT_W   = $clog2(ROOT_W);

    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic OP_OVERLAP  = 1'b0;
    localparam logic OP_DISTANCE = 1'b1;

    typedef struct packed {
        logic                       operation;
        logic signed [COORD_W-1:0]  center_coord;
        logic signed [COORD_W-1:0]  box_low;
        logic signed [COORD_W-1:0]  box_high;
        logic [COORD_W-1:0]         radius;
        logic                       last_dim;
    } in_item_t;

    typedef struct packed {
        logic              overlaps;
        logic [DIST_W-1:0] distance;
        logic              saturated;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic square;
        logic accumulate;
        logic root_start;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic root_done;
        logic out_free;
    } status_t;

endpackage

// ----- hw/rtl/bbo_sqrt.sv -----
// Iterative floor square root, one result bit per cycle.
// Depends on bbo_pkg for widths.
module bbo_sqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [bbo_pkg::SUM_W-1:0] radicand,
    output logic [bbo_pkg::ROOT_W-1:0] root,
    output logic                      done
);
    import bbo_pkg::*;

    logic [SUM_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [REM_W+1:0]  rem_shift;
    logic [REM_W+1:0]  trial;

    always_comb
    begin
        rem_shift = {rem_reg, rad_reg[SUM_W-1:SUM_W-2]};
        trial     = {1'b0, root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[SUM_W-3:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_next  = REM_W'(rem_shift - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

// ----- hw/rtl/bbo_datapath.sv -----
// Datapath: clamp, square, saturating accumulate, root and result register.
// Depends on bbo_pkg and bbo_sqrt.
module bbo_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  bbo_pkg::in_item_t  item,
    input  bbo_pkg::cmd_t      cmd,
    output bbo_pkg::status_t   status,
    output logic               result_valid,
    input  logic               result_ready,
    output bbo_pkg::out_item_t result
);
    import bbo_pkg::*;

    logic signed [COORD_W-1:0] center_reg;
    logic signed [COORD_W-1:0] other_reg;
    logic signed [COORD_W-1:0] other_next;
    logic [COORD_W-1:0]        radius_reg;
    logic                      last_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic [SQ_W-1:0]           rad_sq_reg;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic                      sat_reg, sat_next;
    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_reg, out_next;
    logic signed [COORD_W:0]   diff;
    logic [COORD_W:0]          mag;
    logic [SUM_W:0]            sum_ext;
    logic [ROOT_W-1:0]         root;
    logic                      root_done;
    logic                      out_free;

    always_comb
    begin
        if (item.operation == OP_DISTANCE)
            other_next = item.box_low;
        else if (item.center_coord < item.box_low)
            other_next = item.box_low;
        else if (item.center_coord > item.box_high)
            other_next = item.box_high;
        else
            other_next = item.center_coord;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            center_reg <= item.center_coord;
            other_reg  <= other_next;
            radius_reg <= item.radius;
        end
        if (cmd.square)
            sq_reg <= SQ_W'(mag[MAG_W-1:0]) * SQ_W'(mag[MAG_W-1:0]);
        if (cmd.root_start)
            rad_sq_reg <= SQ_W'(radius_reg) * SQ_W'(radius_reg);
        out_reg <= out_next;
    end

    assign diff = {center_reg[COORD_W-1], center_reg} - {other_reg[COORD_W-1], other_reg};
    assign mag  = diff[COORD_W] ? (COORD_W+1)'(-diff) : diff;

    assign sum_ext = {1'b0, sum_reg} + {{(SUM_W+1-SQ_W){1'b0}}, sq_reg};

    always_comb
    begin
        sum_next = sum_reg;
        sat_next = sat_reg;
        if (cmd.finish)
        begin
            sum_next = '0;
            sat_next = 1'b0;
        end
        else if (cmd.accumulate)
        begin
            if (sum_ext[SUM_W])
            begin
                sum_next = SUM_MAX;
                sat_next = 1'b1;
            end
            else
            begin
                sum_next = sum_ext[SUM_W-1:0];
            end
        end
    end

    bbo_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.root_start),
        .radicand (sum_reg),
        .root     (root),
        .done     (root_done)
    );

    assign out_free = !out_valid_reg || result_ready;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (result_ready)
            out_valid_next = 1'b0;
        if (cmd.finish)
        begin
            out_next.overlaps  = (sum_reg < {{(SUM_W-SQ_W){1'b0}}, rad_sq_reg});
            out_next.distance  = root[ROOT_W-1] ? DIST_MAX : root[DIST_W-1:0];
            out_next.saturated = sat_reg;
            out_valid_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            sat_reg       <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
            if (cmd.load)
                last_reg <= item.last_dim;
        end
    end

    assign status.last      = last_reg;
    assign status.root_done = root_done;
    assign status.out_free  = out_free;
    assign result_valid     = out_valid_reg;
    assign result           = out_reg;

`ifndef SYNTH
    a_sat_sticks_max: assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg |-> sum_reg == SUM_MAX)
        else $error("saturation flag set without a full accumulator");
    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (sum_reg == '0) && !sat_reg)
        else $error("accumulator not cleared after a vector");
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.finish))
        else $error("result register loaded without a finished vector");
`endif

endmodule

// ----- hw/rtl/bbo_ctrl.sv -----
// Controller state machine sequencing square, accumulate, root and output load.
// Depends on bbo_pkg for the command and status structs.
module bbo_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  bbo_pkg::status_t status,
    output bbo_pkg::cmd_t    cmd
);
    import bbo_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_ADD  = 6'b000100,
        S_ROOT = 6'b001000,
        S_WAIT = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign item_ready = (state_reg == S_IDLE) || ((state_reg == S_ADD) && !status.last);
    assign accept     = item_valid && item_ready;

    assign cmd.load       = accept;
    assign cmd.square     = (state_reg == S_MUL);
    assign cmd.accumulate = (state_reg == S_ADD);
    assign cmd.root_start = (state_reg == S_ROOT);
    assign cmd.finish     = (state_reg == S_DONE) && status.out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (status.last)
                    state_next = S_ROOT;
                else if (accept)
                    state_next = S_MUL;
                else
                    state_next = S_IDLE;
            end
            S_ROOT:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (status.root_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTH
    a_root_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.root_done |-> state_reg == S_WAIT)
        else $error("square root finished outside its wait state");
    a_accept_to_square: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_MUL)
        else $error("accepted transaction not squared next cycle");
    a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> state_reg == S_IDLE)
        else $error("controller did not return to idle after a result");
`endif

endmodule

// ----- hw/rtl/box_ball_overlap_test_core.sv -----
// Box/ball overlap test: per-dimension accumulation of squared distance.
// Top level; depends on bbo_pkg, bbo_ctrl, bbo_datapath and bbo_sqrt.
//
// Usage: one input transaction on item_valid/item_ready carries one dimension
// of a vector; the transaction with last_dim set closes the vector and yields
// one result transaction on result_valid/result_ready.
// A dimension that is not the last is squared and then accumulated; the next
// one can be accepted while the previous one is being accumulated.
// The last dimension is followed by the square root unit, which resolves the
// 19-bit root one result bit per cycle; no input is taken until the result
// has been loaded into the output register.
// The result sits in an output register; when the receiver stalls, the block
// finishes its root and then waits until the pending result has been taken or
// is being taken, then loads the new result and returns to idle for a new vector.
// Reset clears the accumulator, the saturation flag and the result valid.
module box_ball_overlap_test_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  bbo_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output bbo_pkg::out_item_t result
);
    import bbo_pkg::*;

    cmd_t    cmd;
    status_t status;

    bbo_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    bbo_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
